/* rtl/core/bmf_pkg.sv */
// Battery monitor filter package: field widths, register indexes, result codes
// and parameter defaults. No dependencies.
`default_nettype none

package bmf_pkg;

   localparam int WINDOW_LOG2_DEFAULT = 3;
   localparam int SAMPLE_BITS_DEFAULT = 12;

   localparam int RAW_W   = 12;
   localparam int MV_W    = 15;
   localparam int PCT_W   = 7;
   localparam int CODE_W  = 2;
   localparam int CSR_W   = 15;
   localparam int CSR_A_W = 2;
   localparam int NUM_W   = 22;
   localparam int QUO_W   = 8;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   localparam logic [CSR_W-1:0] MV_SCALE_RESET = 15'd7200;
   localparam logic [CSR_W-1:0] EMPTY_MV_RESET = 15'd3300;
   localparam logic [CSR_W-1:0] FULL_MV_RESET  = 15'd4200;

   localparam logic [CSR_A_W-1:0] CSR_MV_SCALE = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_EMPTY_MV = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_FULL_MV  = 2'd2;

   localparam logic [PCT_W-1:0] PCT_FULL_SCALE = 7'd100;
   localparam logic [PCT_W-1:0] PCT_FULL_LEVEL = 7'd95;
   localparam logic [PCT_W-1:0] PCT_LOW_LEVEL  = 7'd10;
   localparam logic [PCT_W-1:0] PCT_EMPTY_LEVEL = 7'd5;

   typedef enum logic [CODE_W-1:0] {
      CS_DISCONNECTED = 2'd0,
      CS_CHARGING     = 2'd1,
      CS_COMPLETED    = 2'd2,
      CS_ERROR        = 2'd3
   } charge_state_type;

   typedef enum logic [CODE_W-1:0] {
      LC_EMPTY  = 2'd0,
      LC_LOW    = 2'd1,
      LC_IN_USE = 2'd2,
      LC_FULL   = 2'd3
   } level_class_type;

endpackage

`default_nettype wire

/* rtl/core/battery_monitor_filter.sv */
// A failed conversion goes from acceptance straight to the result state. A good sample is
// scaled, averaged in the window RAM and turned into a percent by an 8-step restoring divide
// on the shared adder, skipped when the span or the level above empty is not positive; the
// first good sample also fills all 2^WINDOW_LOG2 entries of the averaging window RAM.
// One transaction at a time, req_tready high only in idle; a result waits out any output stall.
// Reset: synchronous, active high; clears sequencer and window state, loads register defaults.
// Battery monitor filter top level. Depends on bmf_pkg and bmf_ram.
`default_nettype none

module battery_monitor_filter #(
   parameter int WINDOW_LOG2 = bmf_pkg::WINDOW_LOG2_DEFAULT,
   parameter int SAMPLE_BITS = bmf_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // adc_raw[11:0], charger_error_pin[12], charger_status_pin[13], usb_power[14]
   input  wire logic [bmf_pkg::REQ_DATA_W-1:0]    req_tdata,
   // adc_ok[0]
   input  wire logic                              req_tuser,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // battery_mv[14:0], battery_percent[21:15], charge_state[23:22], level_class[25:24]
   output logic      [bmf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_we,
   input  wire logic [bmf_pkg::CSR_A_W-1:0]       csr_addr,
   input  wire logic [bmf_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int DEPTH = 1 << WINDOW_LOG2;
   localparam int PTR_W = (WINDOW_LOG2 > 0) ? WINDOW_LOG2 : 1;
   localparam int MV_W = bmf_pkg::MV_W;
   localparam int RAW_W = bmf_pkg::RAW_W;
   localparam int SUM_W = MV_W + WINDOW_LOG2;
   localparam int NUM_W = bmf_pkg::NUM_W;
   localparam int QUO_W = bmf_pkg::QUO_W;
   localparam int PCT_W = bmf_pkg::PCT_W;
   localparam int ALU_W = (SUM_W + 1 > NUM_W + 1) ? SUM_W + 1 : NUM_W + 1;
   localparam int PROD_W = RAW_W + bmf_pkg::CSR_W;
   localparam int DCNT_W = $clog2(QUO_W);
   localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'((33'd1 << SAMPLE_BITS) - 33'd1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   typedef enum logic [11:0] {
      S_IDLE   = 12'b0000_0000_0001,
      S_SCALE  = 12'b0000_0000_0010,
      S_FILL   = 12'b0000_0000_0100,
      S_READ   = 12'b0000_0000_1000,
      S_SUBOLD = 12'b0000_0001_0000,
      S_ADDNEW = 12'b0000_0010_0000,
      S_SPAN   = 12'b0000_0100_0000,
      S_DIFF   = 12'b0000_1000_0000,
      S_MUL    = 12'b0001_0000_0000,
      S_DIV    = 12'b0010_0000_0000,
      S_PCT    = 12'b0100_0000_0000,
      S_EMIT   = 12'b1000_0000_0000
   } seq_state_type;

   seq_state_type state_ff, state_in;

   logic [bmf_pkg::CSR_W-1:0] mv_scale_ff, mv_scale_in;
   logic [bmf_pkg::CSR_W-1:0] empty_mv_ff, empty_mv_in;
   logic [bmf_pkg::CSR_W-1:0] full_mv_ff, full_mv_in;

   logic [RAW_W-1:0] raw_ff, raw_in;
   logic             err_pin_ff, err_pin_in;
   logic             stat_pin_ff, stat_pin_in;
   logic             usb_ff, usb_in;
   logic [MV_W-1:0]  mv_ff, mv_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [MV_W-1:0]  span_ff, span_in;
   logic             span_bad_ff, span_bad_in;
   logic [MV_W-1:0]  diff_ff, diff_in;
   logic             below_ff, below_in;
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [PTR_W-1:0] fill_cnt_ff, fill_cnt_in;

   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic             primed_ff, primed_in;
   logic [MV_W-1:0]  filtered_mv_ff, filtered_mv_in;
   logic [PCT_W-1:0] percent_ff, percent_in;

   logic [bmf_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic [ALU_W-1:0] alu_a;
   logic [ALU_W-1:0] alu_b;
   logic             alu_sub;
   logic [ALU_W:0]   alu_res;
   logic             alu_borrow;
   logic             alu_zero;

   logic             ram_we;
   logic [PTR_W-1:0] ram_waddr;
   logic [MV_W-1:0]  ram_rdata;

   logic [PROD_W-1:0] product;
   logic [PTR_W-1:0]  ptr_next;
   logic              req_fire;
   logic              out_free;
   bmf_pkg::charge_state_type cstate;
   bmf_pkg::level_class_type  lclass;

   bmf_ram #(
      .WIDTH (MV_W),
      .DEPTH (DEPTH),
      .ADDR_W(PTR_W)
   ) u_window_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(mv_ff),
      .rd_addr(ptr_ff),
      .rd_data(ram_rdata)
   );

   // shared adder/subtractor
   assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
   assign alu_borrow = alu_sub & alu_res[ALU_W];
   assign alu_zero = (alu_res[ALU_W-1:0] == '0);

   assign product = PROD_W'(raw_ff & RAW_MASK) * PROD_W'(mv_scale_ff);
   assign ptr_next = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + PTR_W'(1);
   assign req_fire = req_tvalid & req_tready;
   assign out_free = ~rsp_valid_ff | rsp_tready;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   assign ram_we = (state_ff == S_FILL) | (state_ff == S_SUBOLD);
   assign ram_waddr = (state_ff == S_FILL) ? fill_cnt_ff : ptr_ff;

   always_comb begin
      unique case (state_ff)
         S_SUBOLD: begin
            alu_a = ALU_W'(sum_ff);
            alu_b = ALU_W'(ram_rdata);
            alu_sub = 1'b1;
         end
         S_ADDNEW: begin
            alu_a = ALU_W'(sum_ff);
            alu_b = ALU_W'(mv_ff);
            alu_sub = 1'b0;
         end
         S_SPAN: begin
            alu_a = ALU_W'(full_mv_ff);
            alu_b = ALU_W'(empty_mv_ff);
            alu_sub = 1'b1;
         end
         S_DIFF: begin
            alu_a = ALU_W'(filtered_mv_ff);
            alu_b = ALU_W'(empty_mv_ff);
            alu_sub = 1'b1;
         end
         S_DIV: begin
            alu_a = ALU_W'(rem_ff);
            alu_b = ALU_W'(span_ff) << dcnt_ff;
            alu_sub = 1'b1;
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
            alu_sub = 1'b0;
         end
      endcase
   end

   always_comb begin
      priority if (!err_pin_ff) begin
         cstate = bmf_pkg::CS_ERROR;
      end else if (!stat_pin_ff) begin
         cstate = bmf_pkg::CS_CHARGING;
      end else if (!usb_ff) begin
         cstate = bmf_pkg::CS_DISCONNECTED;
      end else begin
         cstate = bmf_pkg::CS_COMPLETED;
      end

      priority if (percent_ff > bmf_pkg::PCT_FULL_LEVEL) begin
         lclass = bmf_pkg::LC_FULL;
      end else if (percent_ff > bmf_pkg::PCT_LOW_LEVEL) begin
         lclass = bmf_pkg::LC_IN_USE;
      end else if (percent_ff > bmf_pkg::PCT_EMPTY_LEVEL) begin
         lclass = bmf_pkg::LC_LOW;
      end else begin
         lclass = bmf_pkg::LC_EMPTY;
      end
   end

   always_comb begin
      state_in = state_ff;
      mv_scale_in = mv_scale_ff;
      empty_mv_in = empty_mv_ff;
      full_mv_in = full_mv_ff;
      raw_in = raw_ff;
      err_pin_in = err_pin_ff;
      stat_pin_in = stat_pin_ff;
      usb_in = usb_ff;
      mv_in = mv_ff;
      sum_in = sum_ff;
      span_in = span_ff;
      span_bad_in = span_bad_ff;
      diff_in = diff_ff;
      below_in = below_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dcnt_in = dcnt_ff;
      fill_cnt_in = fill_cnt_ff;
      ptr_in = ptr_ff;
      primed_in = primed_ff;
      filtered_mv_in = filtered_mv_ff;
      percent_in = percent_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      if (csr_we) begin
         unique case (csr_addr)
            bmf_pkg::CSR_MV_SCALE: mv_scale_in = csr_wdata;
            bmf_pkg::CSR_EMPTY_MV: empty_mv_in = csr_wdata;
            bmf_pkg::CSR_FULL_MV:  full_mv_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               raw_in = req_tdata[RAW_W-1:0];
               err_pin_in = req_tdata[RAW_W];
               stat_pin_in = req_tdata[RAW_W+1];
               usb_in = req_tdata[RAW_W+2];
               state_in = req_tuser ? S_SCALE : S_EMIT;
            end
         end
         S_SCALE: begin
            mv_in = MV_W'(product >> SAMPLE_BITS);
            fill_cnt_in = '0;
            state_in = primed_ff ? S_READ : S_FILL;
         end
         S_FILL: begin
            fill_cnt_in = fill_cnt_ff + PTR_W'(1);
            if (fill_cnt_ff == PTR_LAST) begin
               sum_in = SUM_W'(mv_ff) << WINDOW_LOG2;
               primed_in = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_SUBOLD;
         end
         S_SUBOLD: begin
            sum_in = alu_res[SUM_W-1:0];
            ptr_in = ptr_next;
            state_in = S_ADDNEW;
         end
         S_ADDNEW: begin
            sum_in = alu_res[SUM_W-1:0];
            filtered_mv_in = MV_W'(alu_res[SUM_W-1:0] >> WINDOW_LOG2);
            state_in = S_SPAN;
         end
         S_SPAN: begin
            span_in = alu_res[MV_W-1:0];
            span_bad_in = alu_borrow | alu_zero;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            diff_in = alu_res[MV_W-1:0];
            below_in = alu_borrow | alu_zero;
            state_in = S_MUL;
         end
         S_MUL: begin
            rem_in = NUM_W'(diff_ff) * NUM_W'(bmf_pkg::PCT_FULL_SCALE);
            quo_in = '0;
            dcnt_in = DCNT_W'(QUO_W - 1);
            if (span_bad_ff || below_ff) begin
               percent_in = '0;
               state_in = S_EMIT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!alu_borrow) begin
               rem_in = alu_res[NUM_W-1:0];
               quo_in[dcnt_ff] = 1'b1;
            end
            dcnt_in = dcnt_ff - DCNT_W'(1);
            if (dcnt_ff == '0) begin
               state_in = S_PCT;
            end
         end
         S_PCT: begin
            // quotient of 128 or more shows up in the top bit
            if (quo_ff > QUO_W'(bmf_pkg::PCT_FULL_SCALE)) begin
               percent_in = bmf_pkg::PCT_FULL_SCALE;
            end else begin
               percent_in = quo_ff[PCT_W-1:0];
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_data_in = {6'd0, lclass, cstate, percent_ff, filtered_mv_ff};
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mv_scale_ff <= bmf_pkg::MV_SCALE_RESET;
         empty_mv_ff <= bmf_pkg::EMPTY_MV_RESET;
         full_mv_ff <= bmf_pkg::FULL_MV_RESET;
         ptr_ff <= '0;
         primed_ff <= 1'b0;
         filtered_mv_ff <= '0;
         percent_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mv_scale_ff <= mv_scale_in;
         empty_mv_ff <= empty_mv_in;
         full_mv_ff <= full_mv_in;
         ptr_ff <= ptr_in;
         primed_ff <= primed_in;
         filtered_mv_ff <= filtered_mv_in;
         percent_ff <= percent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff <= raw_in;
      err_pin_ff <= err_pin_in;
      stat_pin_ff <= stat_pin_in;
      usb_ff <= usb_in;
      mv_ff <= mv_in;
      sum_ff <= sum_in;
      span_ff <= span_in;
      span_bad_ff <= span_bad_in;
      diff_ff <= diff_in;
      below_ff <= below_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dcnt_ff <= dcnt_in;
      fill_cnt_ff <= fill_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_fail_skips_math: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tuser) |=> (state_ff == S_EMIT))
      else $error("failed conversion did not go straight to result");

   a_percent_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[21:15] <= bmf_pkg::PCT_FULL_SCALE))
      else $error("percent above full scale");

   a_filtered_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_ADDNEW) |=> $stable(filtered_mv_ff))
      else $error("filtered voltage changed outside window update");

   a_unprimed_ptr: assert property (@(posedge clock) disable iff (reset)
      !primed_ff |-> (ptr_ff == '0))
      else $error("window pointer moved before window was filled");

   a_emit_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free) |=> (rsp_tvalid && state_ff == S_IDLE))
      else $error("result not loaded on leaving emit");

endmodule

`default_nettype wire

/* rtl/core/bmf_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module bmf_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* test/battery_monitor_filter_checker.sv */
`timescale 1ns / 100ps
// Checker for the battery monitor filter: watches the register port and both streams,
// predicts each reading from its own gauge model and compares it field by field.
// Depends on bmf_pkg.

module battery_monitor_filter_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bmf_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [bmf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic                           csr_we,
   input  logic [bmf_pkg::CSR_A_W-1:0]    csr_addr,
   input  logic [bmf_pkg::CSR_W-1:0]      csr_wdata,
   output int                             fail_count,
   output int                             due_count,
   output int                             checked_count
);

   localparam int WIN_LOG2 = bmf_pkg::WINDOW_LOG2_DEFAULT;
   localparam int SMP_BITS = bmf_pkg::SAMPLE_BITS_DEFAULT;
   localparam int WIN_LEN  = 1 << WIN_LOG2;
   localparam int MV_W     = bmf_pkg::MV_W;
   localparam int PCT_W    = bmf_pkg::PCT_W;

   typedef struct packed {
      logic [MV_W-1:0]           mv;
      logic [PCT_W-1:0]          pct;
      bmf_pkg::charge_state_type cstate;
      bmf_pkg::level_class_type  lclass;
   } gauge_reading_type;

   logic [bmf_pkg::CSR_W-1:0] scale_reg;
   logic [bmf_pkg::CSR_W-1:0] empty_reg;
   logic [bmf_pkg::CSR_W-1:0] full_reg;
   logic [MV_W-1:0]           avg_window [WIN_LEN];
   logic [WIN_LOG2-1:0]       avg_ptr;
   logic                      avg_primed;
   logic [MV_W-1:0]           avg_mv;
   logic [PCT_W-1:0]          gauge_pct;

   gauge_reading_type readings_due[$];

   task automatic gauge_update(input logic [bmf_pkg::RAW_W-1:0] raw, input logic ok,
                               input logic err_pin, input logic stat_pin, input logic usb,
                               output gauge_reading_type r);
      int unsigned scaled;
      int unsigned total;
      int unsigned ratio;
      int i;
      if (ok) begin
         scaled = ((32'(raw) & ((32'd1 << SMP_BITS) - 1)) * 32'(scale_reg)) >> SMP_BITS;
         scaled = scaled & ((32'd1 << MV_W) - 1);
         if (!avg_primed) begin
            for (i = 0; i < WIN_LEN; i++) avg_window[i] = MV_W'(scaled);
            avg_primed = 1'b1;
         end
         avg_window[avg_ptr] = MV_W'(scaled);
         avg_ptr = avg_ptr + 1'b1;
         total = 0;
         for (i = 0; i < WIN_LEN; i++) total += avg_window[i];
         avg_mv = MV_W'(total >> WIN_LOG2);
         if (full_reg <= empty_reg || avg_mv <= empty_reg) begin
            gauge_pct = '0;
         end else begin
            ratio = (32'(avg_mv) - 32'(empty_reg)) * 32'(bmf_pkg::PCT_FULL_SCALE)
                    / (32'(full_reg) - 32'(empty_reg));
            gauge_pct = (ratio > bmf_pkg::PCT_FULL_SCALE) ? bmf_pkg::PCT_FULL_SCALE
                                                          : PCT_W'(ratio);
         end
      end
      r.mv  = avg_mv;
      r.pct = gauge_pct;
      if (!err_pin)       r.cstate = bmf_pkg::CS_ERROR;
      else if (!stat_pin) r.cstate = bmf_pkg::CS_CHARGING;
      else if (!usb)      r.cstate = bmf_pkg::CS_DISCONNECTED;
      else                r.cstate = bmf_pkg::CS_COMPLETED;
      if (gauge_pct > bmf_pkg::PCT_FULL_LEVEL)       r.lclass = bmf_pkg::LC_FULL;
      else if (gauge_pct > bmf_pkg::PCT_LOW_LEVEL)   r.lclass = bmf_pkg::LC_IN_USE;
      else if (gauge_pct > bmf_pkg::PCT_EMPTY_LEVEL) r.lclass = bmf_pkg::LC_LOW;
      else                                           r.lclass = bmf_pkg::LC_EMPTY;
   endtask

   always @(posedge clock) begin
      gauge_reading_type reading;
      gauge_reading_type want;
      int i;
      if (reset) begin
         scale_reg  = bmf_pkg::MV_SCALE_RESET;
         empty_reg  = bmf_pkg::EMPTY_MV_RESET;
         full_reg   = bmf_pkg::FULL_MV_RESET;
         for (i = 0; i < WIN_LEN; i++) avg_window[i] = '0;
         avg_ptr    = '0;
         avg_primed = 1'b0;
         avg_mv     = '0;
         gauge_pct  = '0;
         readings_due.delete();
         fail_count    = 0;
         checked_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               bmf_pkg::CSR_MV_SCALE: scale_reg = csr_wdata;
               bmf_pkg::CSR_EMPTY_MV: empty_reg = csr_wdata;
               bmf_pkg::CSR_FULL_MV:  full_reg  = csr_wdata;
               default: ;
            endcase
         end
         // results first, so a reading can never match a transaction taken in the same cycle
         if (rsp_tvalid && rsp_tready) begin
            if (readings_due.size() == 0) begin
               $error("unexpected reading 0x%08h with no transaction outstanding", rsp_tdata);
               fail_count++;
            end else begin
               want = readings_due.pop_front();
               checked_count++;
               if (rsp_tdata[14:0] !== want.mv) begin
                  $error("battery_mv: expected %0d, actual %0d", want.mv, rsp_tdata[14:0]);
                  fail_count++;
               end
               if (rsp_tdata[21:15] !== want.pct) begin
                  $error("battery_percent: expected %0d, actual %0d", want.pct,
                         rsp_tdata[21:15]);
                  fail_count++;
               end
               if (rsp_tdata[23:22] !== want.cstate) begin
                  $error("charge_state: expected %0d, actual %0d", want.cstate,
                         rsp_tdata[23:22]);
                  fail_count++;
               end
               if (rsp_tdata[25:24] !== want.lclass) begin
                  $error("level_class: expected %0d, actual %0d", want.lclass,
                         rsp_tdata[25:24]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            gauge_update(req_tdata[11:0], req_tuser, req_tdata[12], req_tdata[13],
                         req_tdata[14], reading);
            readings_due.push_back(reading);
         end
      end
      due_count = readings_due.size();
   end

endmodule

/* test/battery_monitor_filter_test.sv */
`timescale 1ns / 100ps
// Top of the battery monitor filter testbench: clock, reset, register setup and
// measurement stimulus with bursty sender and stalling receiver; verdict from the checker.
// Depends on bmf_pkg, battery_monitor_filter and battery_monitor_filter_checker.

module battery_monitor_filter_test;

   localparam logic [bmf_pkg::CSR_A_W-1:0] CSR_SPARE = 2'd3;

   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_STARVED,
      RX_PERIODIC
   } rx_mode_type;

   logic                           clock;
   logic                           reset      = 1'b1;
   logic [bmf_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           req_tuser  = 1'b0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [bmf_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b1;
   logic                           csr_we     = 1'b0;
   logic [bmf_pkg::CSR_A_W-1:0]    csr_addr   = '0;
   logic [bmf_pkg::CSR_W-1:0]      csr_wdata  = '0;

   int fail_count;
   int due_count;
   int checked_count;

   int unsigned cur_scale = bmf_pkg::MV_SCALE_RESET;
   int unsigned cur_empty = bmf_pkg::EMPTY_MV_RESET;
   int unsigned cur_full  = bmf_pkg::FULL_MV_RESET;
   int event_count   = 0;
   int setting_count = 1;
   int burst_left    = 4;

   rx_mode_type rx_mode  = RX_OPEN;
   int          rx_cycle = 0;

   battery_monitor_filter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   battery_monitor_filter_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .due_count     (due_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   // receiver: stall pattern is re-picked at random from the four modes
   always @(negedge clock) begin
      rx_cycle++;
      if (rx_cycle % 128 == 0) rx_mode = rx_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_OPEN:    rsp_tready <= 1'b1;
         RX_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
         RX_STARVED: rsp_tready <= ($urandom_range(0, 7) == 0);
         default:    rsp_tready <= ((rx_cycle % 6) < 4);
      endcase
   end

   // called at a falling edge; returns at a falling edge after acceptance, later if a burst ends
   task automatic issue_event(input logic [bmf_pkg::RAW_W-1:0] raw, input logic ok,
                              input logic err_pin, input logic stat_pin, input logic usb);
      req_tdata  <= {1'b0, usb, stat_pin, err_pin, raw};
      req_tuser  <= ok;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      event_count++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (due_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_reg(input logic [bmf_pkg::CSR_A_W-1:0] addr,
                          input logic [bmf_pkg::CSR_W-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic program_gauge(input int unsigned scale, input int unsigned empty_v,
                                input int unsigned full_v);
      set_reg(bmf_pkg::CSR_MV_SCALE, bmf_pkg::CSR_W'(scale));
      set_reg(bmf_pkg::CSR_EMPTY_MV, bmf_pkg::CSR_W'(empty_v));
      set_reg(bmf_pkg::CSR_FULL_MV, bmf_pkg::CSR_W'(full_v));
      set_reg(CSR_SPARE, bmf_pkg::CSR_W'($urandom_range(0, 32767)));
      cur_scale = scale;
      cur_empty = empty_v;
      cur_full  = full_v;
      setting_count++;
   endtask

   // mostly samples that land around the empty..full span, some rail values and uniform noise
   task automatic random_event();
      int unsigned lo;
      int unsigned hi;
      int unsigned target;
      int unsigned raw;
      int          pick;
      pick = $urandom_range(0, 99);
      lo = (cur_empty < cur_full) ? cur_empty : cur_full;
      hi = (cur_empty < cur_full) ? cur_full : cur_empty;
      lo = (lo > 300) ? lo - 300 : 0;
      hi = (hi + 300 > 32767) ? 32767 : hi + 300;
      if (pick < 60) begin
         target = $urandom_range(hi, lo);
         raw    = ((target << bmf_pkg::SAMPLE_BITS_DEFAULT) + cur_scale - 1) / cur_scale;
         if (raw > 4095) raw = 4095;
      end else if (pick < 66) begin
         raw = ($urandom_range(0, 1) == 1) ? 4095 : 0;
      end else begin
         raw = $urandom_range(0, 4095);
      end
      issue_event(bmf_pkg::RAW_W'(raw), ($urandom_range(0, 99) < 85),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
   endtask

   initial begin
      int ph;
      int k;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // no sample yet, every charge state
      issue_event(12'hFFF, 1'b0, 1'b0, 1'b1, 1'b1);
      issue_event(12'h000, 1'b0, 1'b1, 1'b0, 1'b0);
      issue_event(12'hABC, 1'b0, 1'b1, 1'b1, 1'b0);
      issue_event(12'h543, 1'b0, 1'b1, 1'b1, 1'b1);
      // first good sample primes the window, above full
      issue_event(12'hFFF, 1'b1, 1'b1, 1'b1, 1'b1);
      issue_event(12'h000, 1'b0, 1'b1, 1'b0, 1'b1);
      // drain the average down through the classes to zero
      for (k = 0; k < 8; k++) issue_event(12'h000, 1'b1, 1'b1, 1'b1, 1'b0);
      issue_event(12'h800, 1'b1, 1'b0, 1'b0, 1'b0);
      issue_event(12'hFFF, 1'b1, 1'b1, 1'b0, 1'b1);
      // full equal to empty, then full below empty
      program_gauge(bmf_pkg::MV_SCALE_RESET, 4000, 4000);
      issue_event(12'hFFF, 1'b1, 1'b1, 1'b1, 1'b1);
      issue_event(12'h900, 1'b1, 1'b1, 1'b1, 1'b0);
      program_gauge(bmf_pkg::MV_SCALE_RESET, bmf_pkg::FULL_MV_RESET, bmf_pkg::EMPTY_MV_RESET);
      issue_event(12'hFFF, 1'b1, 1'b0, 1'b0, 1'b1);
      // percent is only refreshed by the next good sample
      program_gauge(bmf_pkg::MV_SCALE_RESET, bmf_pkg::EMPTY_MV_RESET, bmf_pkg::FULL_MV_RESET);
      issue_event(12'h123, 1'b0, 1'b1, 1'b1, 1'b1);
      issue_event(12'hFFF, 1'b1, 1'b1, 1'b1, 1'b1);

      for (ph = 0; ph < 9; ph++) begin
         case (ph)
            0: program_gauge(bmf_pkg::MV_SCALE_RESET, bmf_pkg::EMPTY_MV_RESET,
                             bmf_pkg::FULL_MV_RESET);
            1: program_gauge(1, 0, 32767);
            2: program_gauge(32767, 0, 32767);
            3: program_gauge(32767, 32767, 0);
            4: program_gauge(20000, 5000, 5000);
            5: program_gauge(4096, 1000, 1100);
            default: begin
               k = $urandom_range(0, 20000);
               program_gauge($urandom_range(1, 32767), k, k + $urandom_range(1, 12000));
            end
         endcase
         repeat (208) random_event();
      end

      wait_idle();
      repeat (40) @(negedge clock);
      $display("summary: %0d measurement transactions over %0d register settings,",
               event_count, setting_count);
      $display("summary: %0d readings compared, %0d mismatches", checked_count, fail_count);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/bmf_pkg.sv
rtl/core/bmf_ram.sv
rtl/core/battery_monitor_filter.sv
test/battery_monitor_filter_checker.sv
test/battery_monitor_filter_test.sv
